### src/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### src/lrs_pkg.sv
package lrs_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int MAX_CHANNELS = 2;
    localparam int LANES        = 2;
    localparam int POS_BITS     = 18;
    localparam int FRAC_BITS    = 16;
    localparam int STEP_BITS    = 18;
    localparam int CHAN_BITS    = 2;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [POS_BITS-1:0]  ONE_Q16  = POS_BITS'(65536);
    localparam logic [STEP_BITS-1:0] STEP_MIN = STEP_BITS'(2048);
    localparam logic [STEP_BITS-1:0] STEP_MAX = STEP_BITS'(131072);
    localparam logic [STEP_BITS-1:0] STEP_RST = STEP_BITS'(65536);
    localparam logic [CHAN_BITS-1:0] CHAN_RST = CHAN_BITS'(1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANS = CFG_IDX_BITS'(1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample [LANES-1:0] t_lanes;

    typedef struct packed {
        t_sample chan0_sample;
        t_sample chan1_sample;
        logic    final_frame;
    } t_in_item;

    typedef struct packed {
        t_sample chan0_out;
        t_sample chan1_out;
        logic    final_out;
    } t_out_item;

endpackage

### src/lrs_interp.sv
module lrs_interp import lrs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_lanes               i_lo,
    input  t_lanes               i_hi,
    input  logic [FRAC_BITS-1:0] i_frac,
    output logic                 o_done,
    output t_lanes               o_result
);

    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int ACC_BITS  = SAMPLE_BITS + 2;
    localparam int CNT_BITS  = $clog2(FRAC_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAC_BITS - 1);

    logic signed [DIFF_BITS-1:0] r_diff [LANES];
    logic signed [DIFF_BITS-1:0] r_acc  [LANES];
    logic signed [ACC_BITS-1:0]  n_sum  [LANES];
    t_lanes                      r_lo;
    logic [FRAC_BITS-1:0]        r_frac;
    logic [CNT_BITS-1:0]         r_cnt;
    logic                        r_busy;
    logic                        r_done;

    // shift-add, one fraction bit per cycle, lsb first; the dropped bit floors
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_sum[l] = ACC_BITS'(r_acc[l]) + (r_frac[0] ? ACC_BITS'(r_diff[l]) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lo   <= i_lo;
            r_frac <= i_frac;
            for (int l = 0; l < LANES; l++) begin
                r_diff[l] <= DIFF_BITS'($signed(i_hi[l])) - DIFF_BITS'($signed(i_lo[l]));
                r_acc[l]  <= '0;
            end
        end else if (r_busy) begin
            r_frac <= r_frac >> 1;
            for (int l = 0; l < LANES; l++) begin
                r_acc[l] <= n_sum[l][ACC_BITS-1:1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_result[l] = r_lo[l] + r_acc[l][SAMPLE_BITS-1:0];
        end
    end

    assign o_done = r_done;

endmodule

### src/linear_interp_resampler.sv
// Linear-interpolation resampler for one or two interleaved 16-bit channels. Each input
// frame yields k output frames (0 to 64), sampled at positions that advance by the
// Q2.16 step register; the last output of a clip is flagged by final_out. Every output
// goes through a bit-serial multiply that consumes one fraction bit per cycle, and each
// output frame passes through the plan, calc and load states in turn. The input side
// stalls while a frame is being worked; one finished output waits in the output register
// without holding up the next input frame. Configuration is taken in any cycle and should
// only change while the block is idle.
`include "assert_macros.svh"

module linear_interp_resampler import lrs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_item                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_item               o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [STEP_BITS-1:0]    i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PLAN,
        S_CALC,
        S_LOAD
    } t_state;

    t_state                r_state;
    logic [STEP_BITS-1:0]  r_step;
    logic [CHAN_BITS-1:0]  r_chan;
    logic [STEP_BITS-1:0]  r_step_use;
    logic                  r_two;
    t_lanes                r_prior;
    t_lanes                r_cur;
    logic                  r_fin;
    logic                  r_phase_b;
    logic [POS_BITS-1:0]   r_pos;
    logic                  r_awaiting;
    logic                  r_final_pend;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [STEP_BITS-1:0]  n_step_sat;
    logic                  n_two;
    logic [POS_BITS-1:0]   n_npos;
    logic [POS_BITS-1:0]   n_pos_wrap;
    logic                  n_emit;
    logic                  n_in_xfer;
    logic                  n_out_free;
    logic                  n_start;
    t_lanes                n_lo;
    logic [FRAC_BITS-1:0]  n_frac;
    logic                  n_done;
    t_lanes                n_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign n_in_xfer  = i_in_valid && !o_in_stall;
    assign n_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_step < STEP_MIN) begin
            n_step_sat = STEP_MIN;
        end else if (r_step > STEP_MAX) begin
            n_step_sat = STEP_MAX;
        end else begin
            n_step_sat = r_step;
        end
    end

    assign n_two      = (MAX_CHANNELS >= 2) && (r_chan >= CHAN_BITS'(2));
    assign n_npos     = r_pos + POS_BITS'(r_step_use);
    assign n_pos_wrap = r_pos - ONE_Q16;
    assign n_emit     = (r_pos < ONE_Q16);
    assign n_start    = (r_state == S_PLAN) && n_emit;
    assign n_lo       = r_phase_b ? r_cur : r_prior;
    assign n_frac     = r_phase_b ? '0 : r_pos[FRAC_BITS-1:0];

    lrs_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (n_start),
        .i_lo     (n_lo),
        .i_hi     (r_cur),
        .i_frac   (n_frac),
        .o_done   (n_done),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_RST;
            r_chan      <= CHAN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_STEP:  r_step <= i_cfg_data;
                CFG_CHANS: r_chan <= i_cfg_data[CHAN_BITS-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prior     <= '0;
            r_pos       <= '0;
            r_awaiting  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // the load state refills the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_LOAD)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_in_xfer) begin
                        r_cur[0]   <= i_in_data.chan0_sample;
                        r_cur[1]   <= i_in_data.chan1_sample;
                        r_fin      <= i_in_data.final_frame;
                        r_step_use <= n_step_sat;
                        r_two      <= n_two;
                        if (r_awaiting) begin
                            r_prior[0] <= i_in_data.chan0_sample;
                            r_prior[1] <= i_in_data.chan1_sample;
                            r_pos      <= '0;
                            if (i_in_data.final_frame) begin
                                r_phase_b <= 1'b1;
                                r_state   <= S_PLAN;
                            end else begin
                                r_awaiting <= 1'b0;
                            end
                        end else begin
                            r_phase_b <= 1'b0;
                            r_state   <= S_PLAN;
                        end
                    end
                end
                S_PLAN: begin
                    if (n_emit) begin
                        // flag the output after which no further position is served
                        r_final_pend <= r_phase_b ? (n_npos >= ONE_Q16)
                                                  : (r_fin && (n_npos >= (ONE_Q16 << 1)));
                        r_state      <= S_CALC;
                    end else if (!r_phase_b) begin
                        r_pos <= n_pos_wrap;
                        if (r_fin) begin
                            r_phase_b <= 1'b1;
                        end else begin
                            r_prior <= r_cur;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_pos      <= '0;
                        r_awaiting <= 1'b1;
                        r_prior    <= r_cur;
                        r_state    <= S_IDLE;
                    end
                end
                S_CALC: begin
                    if (n_done) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (n_out_free) begin
                        r_out_valid     <= 1'b1;
                        r_out.chan0_out <= n_result[0];
                        r_out.chan1_out <= r_two ? n_result[1] : '0;
                        r_out.final_out <= r_final_pend;
                        r_pos           <= n_npos;
                        r_state         <= S_PLAN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLIES(a_done_in_calc, i_clk, i_rst_n, n_done, r_state == S_CALC)
    `ASSERT_IMPLIES(a_calc_frac_range, i_clk, i_rst_n, r_state == S_CALC, r_pos < ONE_Q16)
    `ASSERT_IMPLIES(a_pending_range, i_clk, i_rst_n, r_state == S_IDLE,
                    r_pos < (ONE_Q16 << 1))
    `ASSERT_NEXT(a_load_moves, i_clk, i_rst_n, (r_state == S_LOAD) && n_out_free,
                 o_out_valid && (r_state == S_PLAN))

endmodule

### tb/linear_interp_resampler_tb.sv
module linear_interp_resampler_tb;
    import lrs_pkg::*;

    localparam int MAX_OUT       = 64;
    localparam int SETTLE_CYCLES = 1300;
    localparam int LIMIT_CYCLES  = 4000000;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = CFG_IDX_BITS'(3);

    class interp_scoreboard;
        t_out_item   due_frames[$];
        logic [STEP_BITS-1:0] step_reg;
        logic [CHAN_BITS-1:0] chans_reg;
        longint      prior0;
        longint      prior1;
        int unsigned next_pos;
        bit          clip_start;
        int          errors;

        function new();
            step_reg   = STEP_RST;
            chans_reg  = CHAN_RST;
            prior0     = 0;
            prior1     = 0;
            next_pos   = 0;
            clip_start = 1'b1;
            errors     = 0;
        endfunction

        function void apply_config(logic [CFG_IDX_BITS-1:0] idx, logic [STEP_BITS-1:0] val);
            if (idx == CFG_STEP) begin
                step_reg = val;
            end else if (idx == CFG_CHANS) begin
                chans_reg = val[CHAN_BITS-1:0];
            end
        endfunction

        // floor of the scaled difference: arithmetic shift rounds toward minus infinity
        function longint lerp(longint lo, longint hi, int unsigned frac);
            return lo + (((hi - lo) * longint'(frac)) >>> FRAC_BITS);
        endfunction

        function void push_frame(longint lo0, longint lo1, longint hi0, longint hi1,
                                 int unsigned frac, int unsigned ch);
            t_out_item r;
            r.chan0_out = SAMPLE_BITS'(lerp(lo0, hi0, frac));
            r.chan1_out = (ch >= 2) ? SAMPLE_BITS'(lerp(lo1, hi1, frac)) : '0;
            r.final_out = 1'b0;
            due_frames = {due_frames, r};
        endfunction

        function void take_frame(t_in_item f);
            int unsigned stp;
            int unsigned ch;
            int unsigned pos;
            int          n;
            longint      cur0;
            longint      cur1;
            t_out_item   r;
            stp = 32'(step_reg);
            if (stp < STEP_MIN) stp = 32'(STEP_MIN);
            if (stp > STEP_MAX) stp = 32'(STEP_MAX);
            ch = 32'(chans_reg);
            if (ch < 1) ch = 1;
            if (ch > MAX_CHANNELS) ch = MAX_CHANNELS;
            cur0 = longint'(f.chan0_sample);
            cur1 = longint'(f.chan1_sample);
            pos  = next_pos;
            n    = 0;
            if (clip_start) begin
                clip_start = 1'b0;
                pos = 0;
            end else begin
                while (pos < ONE_Q16 && n < MAX_OUT) begin
                    push_frame(prior0, prior1, cur0, cur1, pos, ch);
                    n++;
                    pos += stp;
                end
                pos = (pos >= ONE_Q16) ? pos - ONE_Q16 : 0;
            end
            prior0 = cur0;
            prior1 = cur1;
            if (!f.final_frame) begin
                next_pos = pos & 32'h3FFFF;
                return;
            end
            // tail of the clip holds the last frame
            while (pos < ONE_Q16 && n < MAX_OUT) begin
                push_frame(cur0, cur1, cur0, cur1, 0, ch);
                n++;
                pos += stp;
            end
            if (n > 0) begin
                r = due_frames[$];
                r.final_out = 1'b1;
                due_frames[$] = r;
            end
            next_pos   = 0;
            clip_start = 1'b1;
        endfunction

        function void check_output(t_out_item got);
            t_out_item want;
            if (due_frames.size() == 0) begin
                $display("%0t: unexpected output, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = due_frames.pop_front();
            if (got.chan0_out !== want.chan0_out) begin
                $display("%0t: chan0_out expected %0d actual %0d",
                         $time, want.chan0_out, got.chan0_out);
                errors++;
            end
            if (got.chan1_out !== want.chan1_out) begin
                $display("%0t: chan1_out expected %0d actual %0d",
                         $time, want.chan1_out, got.chan1_out);
                errors++;
            end
            if (got.final_out !== want.final_out) begin
                $display("%0t: final_out expected %0b actual %0b",
                         $time, want.final_out, got.final_out);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    t_in_item                i_in_data;
    logic                    o_out_valid;
    logic                    i_out_stall;
    t_out_item               o_out_data;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [STEP_BITS-1:0]    i_cfg_data;

    interp_scoreboard book;
    int               in_idle_pct;
    int               out_idle_pct;
    int               cycles;

    linear_interp_resampler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            book.check_output(o_out_data);
        end
    end

    function automatic t_in_item mk_frame(int a, int b, logic fin);
        t_in_item f;
        f.chan0_sample = t_sample'(a);
        f.chan1_sample = t_sample'(b);
        f.final_frame  = fin;
        return f;
    endfunction

    function automatic int rnd_sample();
        case ($urandom_range(9))
            0: return 32767;
            1: return -32768;
            2: return 0;
            default: return int'(t_sample'($urandom));
        endcase
    endfunction

    // called just after a falling edge; leaves valid high for a following transfer
    task automatic send_frame(input t_in_item f);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        do @(posedge i_clk); while (o_in_stall);
        book.take_frame(f);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (book.due_frames.size() != 0) @(posedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        wait_drained();
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [STEP_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        book.apply_config(idx, val);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [STEP_BITS-1:0] step_val,
                             input logic [STEP_BITS-1:0] chans_val, input bit spare);
        // frames that emit nothing may still be in flight
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        cfg_write(CFG_STEP, step_val);
        cfg_write(CFG_CHANS, chans_val);
        if (spare) begin
            cfg_write(CFG_SPARE_A, STEP_BITS'($urandom));
            cfg_write(CFG_SPARE_B, STEP_BITS'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_clips(input int n_items);
        int k;
        int len;
        int j;
        logic fin;
        k = 0;
        while (k < n_items) begin
            len = $urandom_range(1, 10);
            for (j = 0; j < len && k < n_items; j++) begin
                fin = (j == len - 1);
                if ($urandom_range(99) < 15) fin = 1'($urandom_range(1));
                if (k == n_items - 1) fin = 1'b1;
                if (k == n_items / 2 || $urandom_range(99) < 4) hold_until_drained();
                send_frame(mk_frame(rnd_sample(), rnd_sample(), fin));
                k++;
            end
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        int p;
        book         = new();
        cycles       = 0;
        in_idle_pct  = 12;
        out_idle_pct = 12;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, single-frame clip then a short clip
        send_frame(mk_frame(32767, -32768, 1'b1));
        send_frame(mk_frame(-32768, 32767, 1'b0));
        send_frame(mk_frame(32767, -32768, 1'b0));
        send_frame(mk_frame(-32768, 0, 1'b0));
        send_frame(mk_frame(0, 32767, 1'b1));
        i_in_valid <= 1'b0;

        configure(STEP_BITS'(98304), STEP_BITS'(2), 1'b0);
        send_frame(mk_frame(-32768, 32767, 1'b0));
        send_frame(mk_frame(32767, -32768, 1'b0));
        send_frame(mk_frame(-1, 1, 1'b0));
        send_frame(mk_frame(32767, 32767, 1'b0));
        send_frame(mk_frame(-32768, -32768, 1'b1));
        i_in_valid <= 1'b0;

        // finest step: a two-frame clip gives the largest burst
        configure(STEP_MIN, STEP_BITS'(2), 1'b0);
        send_frame(mk_frame(12345, -12345, 1'b1));
        send_frame(mk_frame(-32768, 32767, 1'b0));
        send_frame(mk_frame(32767, -32768, 1'b1));
        i_in_valid <= 1'b0;

        configure(STEP_MAX, STEP_BITS'(1), 1'b0);
        send_frame(mk_frame(100, -100, 1'b0));
        send_frame(mk_frame(-32768, 1, 1'b0));
        send_frame(mk_frame(32767, 2, 1'b1));
        i_in_valid <= 1'b0;

        configure(STEP_RST, STEP_BITS'(2), 1'b0);
        run_clips(45);
        configure(STEP_MIN, STEP_BITS'(1), 1'b0);
        run_clips(25);
        configure(STEP_MAX, {16'($urandom), 2'd2}, 1'b1);
        run_clips(45);
        // out of range settings saturate
        configure(STEP_BITS'($urandom_range(0, 2047)), {16'($urandom), 2'd0}, 1'b0);
        run_clips(30);
        configure(STEP_BITS'($urandom_range(131073, 262143)), {16'($urandom), 2'd3}, 1'b0);
        run_clips(45);
        for (p = 0; p < 4; p++) begin
            configure(STEP_BITS'($urandom_range(STEP_MIN, STEP_MAX)),
                      {16'($urandom), 2'($urandom_range(3))}, 1'b0);
            if (p == 2) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            run_clips(45);
            in_idle_pct  = 12;
            out_idle_pct = 12;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (book.errors == 0 && book.due_frames.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
